### hw/rtl/soc_pkg.sv
// Shared constants, types and helpers for the segment obstacle clearance unit.
package soc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_OBSTACLES = 32;
    localparam int CNT_W         = 6;
    localparam int ENTRY_W       = 5;
    localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int N_W           = $clog2(MAX_OBSTACLES + 1);
    localparam int OP_W          = COORD_BITS + 1;
    localparam int PROD_W        = 2 * OP_W;
    localparam int F_W           = PROD_W + 2;
    localparam int RECT_W        = 4 * COORD_BITS;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [0:0] REG_COUNT = 1'b0;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OP_W-1:0]       t_opnd;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_opnd  lh;
        t_opnd  lw;
    } t_seg;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_X1Y2,
        MOP_X2Y1,
        MOP_LH_L,
        MOP_LH_R,
        MOP_LW_T,
        MOP_LW_B
    } t_mop;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LD_C,
        ACC_SUB_C,
        ACC_LD_LC,
        ACC_LD_RC,
        ACC_LD_PT,
        ACC_EVAL
    } t_acc;

    typedef struct packed {
        t_mop mop;
        t_acc acc;
    } t_ctl;

    function automatic logic [N_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [N_W-1:0] n;
        if (int'(c) > MAX_OBSTACLES) begin
            n = N_W'(MAX_OBSTACLES);
        end else begin
            n = N_W'(c);
        end
        return n;
    endfunction

endpackage

### hw/rtl/soc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module soc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/soc_arith.sv
// Shared multiplier with operand select, partial sums and the per-rectangle hit test.
module soc_arith import soc_pkg::*; (
    input  logic  i_clk,
    input  t_ctl  i_ctl,
    input  t_seg  i_seg,
    input  t_rect i_rect,
    output logic  o_hit
);

    localparam int F_LT = 0;
    localparam int F_RB = 1;
    localparam int F_LB = 2;
    localparam int F_RT = 3;

    logic signed [OP_W-1:0]   w_a;
    logic signed [OP_W-1:0]   w_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [F_W-1:0]    w_prod_f;
    logic signed [F_W-1:0]    r_c;
    logic signed [F_W-1:0]    r_lc;
    logic signed [F_W-1:0]    r_rc;
    logic signed [F_W-1:0]    r_pt;
    logic signed [F_W-1:0]    w_f [4];
    logic [3:0]               r_neg;
    logic [3:0]               r_zero;
    logic                     r_reject;
    logic                     w_reject;
    t_coord                   w_lo_x;
    t_coord                   w_hi_x;
    t_coord                   w_lo_y;
    t_coord                   w_hi_y;

    function automatic logic opp(input logic pn, input logic pz,
                                 input logic qn, input logic qz);
        return (!pn && (qn || qz)) || ((pn || pz) && !qn);
    endfunction

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_ctl.mop)
            MOP_X1Y2: begin
                w_a = {i_seg.x1[COORD_BITS-1], i_seg.x1};
                w_b = {i_seg.y2[COORD_BITS-1], i_seg.y2};
            end
            MOP_X2Y1: begin
                w_a = {i_seg.x2[COORD_BITS-1], i_seg.x2};
                w_b = {i_seg.y1[COORD_BITS-1], i_seg.y1};
            end
            MOP_LH_L: begin
                w_a = i_seg.lh;
                w_b = {i_rect.left[COORD_BITS-1], i_rect.left};
            end
            MOP_LH_R: begin
                w_a = i_seg.lh;
                w_b = {i_rect.right[COORD_BITS-1], i_rect.right};
            end
            MOP_LW_T: begin
                w_a = i_seg.lw;
                w_b = {i_rect.top[COORD_BITS-1], i_rect.top};
            end
            MOP_LW_B: begin
                w_a = i_seg.lw;
                w_b = {i_rect.bottom[COORD_BITS-1], i_rect.bottom};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod_f = {{(F_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // line value at the four corners
    assign w_f[F_LT] = r_lc + r_pt;
    assign w_f[F_RB] = r_rc + w_prod_f;
    assign w_f[F_LB] = r_lc + w_prod_f;
    assign w_f[F_RT] = r_rc + r_pt;

    always_comb begin
        w_lo_x = (i_rect.left < i_rect.right) ? i_rect.left : i_rect.right;
        w_hi_x = (i_rect.left < i_rect.right) ? i_rect.right : i_rect.left;
        w_lo_y = (i_rect.top < i_rect.bottom) ? i_rect.top : i_rect.bottom;
        w_hi_y = (i_rect.top < i_rect.bottom) ? i_rect.bottom : i_rect.top;
        w_reject = (i_seg.x1 < w_lo_x && i_seg.x2 < w_lo_x) ||
                   (i_seg.x1 > w_hi_x && i_seg.x2 > w_hi_x) ||
                   (i_seg.y1 > w_hi_y && i_seg.y2 > w_hi_y) ||
                   (i_seg.y1 < w_lo_y && i_seg.y2 < w_lo_y);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        case (i_ctl.acc)
            ACC_LD_C:  r_c  <= w_prod_f;
            ACC_SUB_C: r_c  <= r_c - w_prod_f;
            ACC_LD_LC: r_lc <= w_prod_f + r_c;
            ACC_LD_RC: r_rc <= w_prod_f + r_c;
            ACC_LD_PT: r_pt <= w_prod_f;
            ACC_EVAL: begin
                for (int i = 0; i < 4; i++) begin
                    r_neg[i]  <= w_f[i][F_W-1];
                    r_zero[i] <= (w_f[i] == '0);
                end
                r_reject <= w_reject;
            end
            default: begin
            end
        endcase
    end

    assign o_hit = (opp(r_neg[F_LT], r_zero[F_LT], r_neg[F_RB], r_zero[F_RB]) ||
                    opp(r_neg[F_LB], r_zero[F_LB], r_neg[F_RT], r_zero[F_RT])) &&
                   !r_reject;

endmodule

### hw/rtl/segment_obstacle_clearance_unit.sv
// Top level: obstacle table, query sequencer, output register and register port.
// A load word writes one rectangle into the table. A query word runs over n rectangles,
// where n is obstacle_count limited to the table size, and stops early at the first
// rectangle hit; a count of zero answers clear without reading the table. One
// shared multiplier forms the four corner products of each rectangle, and each
// rectangle passes through states M0, M1, M2, M3, EV and DC. The answer lands in an
// output register, and the unit is ready for the next word while that answer waits.
module segment_obstacle_clearance_unit import soc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  t_coord             i_rect_left,
    input  t_coord             i_rect_top,
    input  t_coord             i_rect_right,
    input  t_coord             i_rect_bottom,
    input  t_coord             i_start_x,
    input  t_coord             i_start_y,
    input  t_coord             i_end_x,
    input  t_coord             i_end_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_route_clear,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_C1   = 11'b000_0000_0010,
        S_C2   = 11'b000_0000_0100,
        S_C3   = 11'b000_0000_1000,
        S_M0   = 11'b000_0001_0000,
        S_M1   = 11'b000_0010_0000,
        S_M2   = 11'b000_0100_0000,
        S_M3   = 11'b000_1000_0000,
        S_EV   = 11'b001_0000_0000,
        S_DC   = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [N_W-1:0]     r_n, n_n;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_last, n_last;
    logic               r_res, n_res;
    logic               r_valid, n_valid;
    logic               r_clear, n_clear;
    t_seg               r_seg;
    t_ctl               w_ctl;
    t_rect              w_rect;
    logic [RECT_W-1:0]  w_rdata;
    logic               w_in_acc;
    logic               w_query;
    logic               w_we;
    logic               w_hit;
    logic               w_reg_wr;
    logic [N_W-1:0]     w_n_sat;

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_query  = w_in_acc && (i_func == FUNC_QUERY);
    assign w_we     = w_in_acc && (i_func == FUNC_LOAD) &&
                      (int'(i_entry_index) < MAX_OBSTACLES);
    assign w_n_sat  = sat_count(r_count);
    assign w_rect   = t_rect'(w_rdata);

    soc_ram #(
        .WIDTH (RECT_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IDX_W'(i_entry_index)),
        .i_wdata ({i_rect_left, i_rect_top, i_rect_right, i_rect_bottom}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    soc_arith u_arith (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_seg  (r_seg),
        .i_rect (w_rect),
        .o_hit  (w_hit)
    );

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_idx   = r_idx;
        n_last  = r_last;
        n_res   = r_res;
        n_valid = r_valid;
        n_clear = r_clear;
        w_ctl   = '{mop: MOP_NONE, acc: ACC_NONE};
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_idx = '0;
                    n_n   = w_n_sat;
                    if (w_n_sat == '0) begin
                        n_res   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_C1;
                    end
                end
            end
            S_C1: begin
                w_ctl   = '{mop: MOP_X1Y2, acc: ACC_NONE};
                n_state = S_C2;
            end
            S_C2: begin
                w_ctl   = '{mop: MOP_X2Y1, acc: ACC_LD_C};
                n_state = S_C3;
            end
            S_C3: begin
                w_ctl   = '{mop: MOP_NONE, acc: ACC_SUB_C};
                n_state = S_M0;
            end
            S_M0: begin
                w_ctl   = '{mop: MOP_LH_L, acc: ACC_NONE};
                n_state = S_M1;
            end
            S_M1: begin
                w_ctl   = '{mop: MOP_LH_R, acc: ACC_LD_LC};
                n_state = S_M2;
            end
            S_M2: begin
                w_ctl   = '{mop: MOP_LW_T, acc: ACC_LD_RC};
                n_state = S_M3;
            end
            S_M3: begin
                w_ctl   = '{mop: MOP_LW_B, acc: ACC_LD_PT};
                n_state = S_EV;
            end
            S_EV: begin
                // table read moves on to the next entry here
                w_ctl   = '{mop: MOP_NONE, acc: ACC_EVAL};
                n_last  = (N_W'(r_idx) + N_W'(1)) == r_n;
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_DC;
            end
            S_DC: begin
                if (w_hit) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (r_last) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_M0;
                end
            end
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    n_valid = 1'b1;
                    n_clear = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_n     <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_res   <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_last  <= n_last;
            r_res   <= n_res;
            r_clear <= n_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_seg.x1 <= i_start_x;
            r_seg.y1 <= i_start_y;
            r_seg.x2 <= i_end_x;
            r_seg.y2 <= i_end_y;
            r_seg.lh <= {i_start_y[COORD_BITS-1], i_start_y} -
                        {i_end_y[COORD_BITS-1], i_end_y};
            r_seg.lw <= {i_end_x[COORD_BITS-1], i_end_x} -
                        {i_start_x[COORD_BITS-1], i_start_x};
        end
    end

    assign o_valid       = r_valid;
    assign o_route_clear = r_clear;

    // register port
    assign pready   = 1'b1;
    assign w_reg_wr = psel && penable && pwrite && pready &&
                      (paddr[ADDR_W-1] == REG_COUNT);
    assign prdata   = (paddr[ADDR_W-1] == REG_COUNT) ? DATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_reg_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0) |-> (N_W'(r_idx) < r_n))
        else $error("rectangle index beyond obstacle count");

    a_hit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DC && w_hit) |=> (r_state == S_DONE && !r_res))
        else $error("hit did not end the query as blocked");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_valid && !i_ready) |=>
            (r_state == S_DONE && $stable(o_route_clear)))
        else $error("pending answer overwrote a stalled word");

endmodule
